// ----- sv/bsc_pkg.sv -----
// ============================================================================
// bsc_pkg
// Shared types, constants and the pressure program of the barometric sensor
// compensation block.
// ============================================================================
package bsc_pkg;

    // Widths of the item fields.
    localparam int unsigned RAW_W   = 24;
    localparam int unsigned TEMP_W  = 24;
    localparam int unsigned PRESS_W = 26;
    localparam int unsigned NT_W    = 59;    // linearized temperature over 2^48
    localparam int unsigned WIDE_W  = 256;   // pressure accumulator over 2^181
    localparam int unsigned LIMB_W  = 32;
    localparam int unsigned MULT_W  = 64;    // sign-extended multiplier word

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned TCAL_W      = 40;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_CAL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_HIGH = 2'd2;

    // Saturation limits.
    localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 24'sh7FFFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN  = 24'sh800000;
    localparam logic [PRESS_W-1:0]       PRESS_MAX = 26'h3FFFFFF;

    // Rounding points: temperature drops 32 fraction bits, pressure 173.
    localparam int unsigned T_SHIFT = 32;
    localparam int unsigned P_SHIFT = 173;

    // Queue between the temperature front and the pressure back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Pressure program sequencing.
    localparam int unsigned STEP_W       = 4;
    localparam int unsigned CNT_W        = 5;
    localparam logic [STEP_W-1:0] LAST_STEP   = 4'd13;
    localparam logic [CNT_W-1:0]  PP_LAST_CNT = 5'd14;  // last partial product issued
    localparam logic [CNT_W-1:0]  MAC_LAST_CNT = 5'd16; // sign correction and write back
    localparam logic [CNT_W-1:0]  HI_LIMB_CNT = 5'd8;   // first product on the upper limb

    // One item handed from the front to the back.
    typedef struct packed {
        logic signed [NT_W-1:0]   nt;
        logic [RAW_W-1:0]         p;
        logic signed [TEMP_W-1:0] tq;
        logic                     tsat;
    } bsc_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } bsc_state_t;

    typedef enum logic {
        OP_LOAD,
        OP_MAC
    } bsc_opk_t;

    typedef enum logic {
        REG_R,
        REG_Q
    } bsc_reg_t;

    typedef enum logic {
        MUL_P,
        MUL_T
    } bsc_mul_t;

    // Addends: calibration coefficients already placed at their binary point,
    // or the coefficient register.
    typedef enum logic [3:0] {
        TERM_P4,
        TERM_P8,
        TERM_P3,
        TERM_P7,
        TERM_Q,
        TERM_P10,
        TERM_A2,
        TERM_P6,
        TERM_P11,
        TERM_P9,
        TERM_A1,
        TERM_P5
    } bsc_term_t;

    typedef struct packed {
        bsc_opk_t  kind;
        bsc_reg_t  src;
        bsc_reg_t  dst;
        bsc_mul_t  mul;
        bsc_term_t add;
    } bsc_op_t;

    // Horner evaluation in t of coefficients that are themselves Horner
    // evaluations in p. A MAC step computes dst = src * mul + add.
    function automatic bsc_op_t bsc_prog(input logic [STEP_W-1:0] step);
        bsc_op_t op;
        op = '{kind: OP_LOAD, src: REG_R, dst: REG_R, mul: MUL_P, add: TERM_P4};
        unique case (step)
            4'd0:  op = '{kind: OP_LOAD, src: REG_R, dst: REG_R, mul: MUL_P, add: TERM_P4};
            4'd1:  op = '{kind: OP_MAC,  src: REG_R, dst: REG_R, mul: MUL_P, add: TERM_P8};
            4'd2:  op = '{kind: OP_LOAD, src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P3};
            4'd3:  op = '{kind: OP_MAC,  src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P7};
            4'd4:  op = '{kind: OP_MAC,  src: REG_R, dst: REG_R, mul: MUL_T, add: TERM_Q};
            4'd5:  op = '{kind: OP_LOAD, src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P10};
            4'd6:  op = '{kind: OP_MAC,  src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_A2};
            4'd7:  op = '{kind: OP_MAC,  src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P6};
            4'd8:  op = '{kind: OP_MAC,  src: REG_R, dst: REG_R, mul: MUL_T, add: TERM_Q};
            4'd9:  op = '{kind: OP_LOAD, src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P11};
            4'd10: op = '{kind: OP_MAC,  src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P9};
            4'd11: op = '{kind: OP_MAC,  src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_A1};
            4'd12: op = '{kind: OP_MAC,  src: REG_Q, dst: REG_Q, mul: MUL_P, add: TERM_P5};
            4'd13: op = '{kind: OP_MAC,  src: REG_R, dst: REG_R, mul: MUL_T, add: TERM_Q};
            default: op = '{kind: OP_LOAD, src: REG_R, dst: REG_R, mul: MUL_P, add: TERM_P4};
        endcase
        return op;
    endfunction

    // A 17-bit signed coefficient sign-extended to the wide word and shifted.
    function automatic logic [WIDE_W-1:0] bsc_term(input logic signed [16:0] v,
                                                   input int unsigned sh);
        logic [WIDE_W-1:0] w;
        w = {{(WIDE_W-17){v[16]}}, v};
        return w << sh;
    endfunction

endpackage

// ----- sv/barometric_sensor_compensation_top.sv -----
// ============================================================================
// barometric_sensor_compensation_top
// Compensates a pair of raw barometer samples into temperature (Q8.16 degrees
// Celsius) and pressure (Pa times 256) using the calibration polynomial.
// ============================================================================
// Each item on the input stream carries a 24-bit raw temperature and a 24-bit
// raw pressure sample and produces exactly one result item, in order. The
// temperature path is a four-stage pipeline that takes an item in every cycle
// until the queue behind it is full. The pressure polynomial is evaluated
// exactly on a 256-bit accumulator by a single shared 32x32 multiplier: four
// coefficient loads and ten multiply-accumulate steps, plus taking an item from
// the queue and rounding it. The engine holds one item until its result is
// registered, so it takes no new item before then, and it sets the sustained
// rate. Calibration registers are to be written through the cfg port only
// while no item is in flight; the block itself does not enforce this. All of
// them reset to zero.
module barometric_sensor_compensation_top #(
    parameter int unsigned QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Calibration write port: index 0 temperature bytes, 1 pressure bytes
    // 0 to 7, 2 pressure bytes 8 to 15. Other indexes are ignored.
    input  logic                               cfg_we,
    input  logic [bsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: raw_temperature [23:0], raw_pressure [47:24].
    input  logic [47:0]                        s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: temperature_q16 [23:0], pressure_q8 [49:24], zero pad.
    output logic [55:0]                        m_tdata,
    // Fields from bit 0: saturated.
    output logic                               m_tuser
);

    logic [bsc_pkg::TCAL_W-1:0]     temp_cal_reg;
    logic [bsc_pkg::CFG_DATA_W-1:0] press_low_reg;
    logic [bsc_pkg::CFG_DATA_W-1:0] press_high_reg;

    logic              front_valid;
    bsc_pkg::bsc_job_t front_job;
    logic              queue_full;
    logic              queue_empty;
    logic              queue_pop;
    bsc_pkg::bsc_job_t queue_head;

    logic signed [bsc_pkg::TEMP_W-1:0] temperature_q16;
    logic [bsc_pkg::PRESS_W-1:0]       pressure_q8;

    // Calibration registers. Bits above a register's width are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bsc_pkg::CFG_TEMP_CAL:   temp_cal_reg   <= cfg_wdata[bsc_pkg::TCAL_W-1:0];
                bsc_pkg::CFG_PRESS_LOW:  press_low_reg  <= cfg_wdata;
                bsc_pkg::CFG_PRESS_HIGH: press_high_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front: accepts items and computes the temperature result.
    bsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .temp_cal        (temp_cal_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .raw_temperature (s_tdata[23:0]),
        .raw_pressure    (s_tdata[47:24]),
        .job_valid       (front_valid),
        .job             (front_job),
        .queue_full      (queue_full)
    );

    // The queue lets the front keep accepting while the engine is busy.
    bsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_valid),
        .push_job (front_job),
        .full     (queue_full),
        .pop      (queue_pop),
        .head_job (queue_head),
        .empty    (queue_empty)
    );

    // Back: pressure polynomial and the output register.
    bsc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .press_low       (press_low_reg),
        .press_high      (press_high_reg),
        .queue_empty     (queue_empty),
        .queue_head      (queue_head),
        .queue_pop       (queue_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .temperature_q16 (temperature_q16),
        .pressure_q8     (pressure_q8),
        .saturated       (m_tuser)
    );

    assign m_tdata = {6'd0, pressure_q8, temperature_q16};

endmodule

// ----- sv/bsc_fifo.sv -----
// ============================================================================
// bsc_fifo
// Small queue of items between the temperature front and the pressure back.
// ============================================================================
module bsc_fifo #(
    parameter int unsigned DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bsc_pkg::bsc_job_t push_job,
    output logic              full,
    input  logic              pop,
    output bsc_pkg::bsc_job_t head_job,
    output logic              empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bsc_pkg::bsc_job_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/bsc_front.sv -----
// ============================================================================
// bsc_front
// Input stage: four-stage pipeline that linearizes the raw temperature and
// forms the rounded, saturated temperature result.
// ============================================================================
module bsc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bsc_pkg::TCAL_W-1:0]        temp_cal,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bsc_pkg::RAW_W-1:0]         raw_temperature,
    input  logic [bsc_pkg::RAW_W-1:0]         raw_pressure,
    output logic                              job_valid,
    output bsc_pkg::bsc_job_t                 job,
    input  logic                              queue_full
);

    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [7:0]  t3;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic en;

    logic signed [24:0] d_reg, d_next;
    logic [bsc_pkg::RAW_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [40:0] dt2_reg, dt2_next;
    logic signed [49:0] dd_reg, dd_next;
    logic signed [57:0] ddt3;
    logic signed [59:0] nt_wide;
    logic signed [bsc_pkg::NT_W-1:0] nt_reg, nt_next;
    logic signed [59:0] rnd;
    logic signed [27:0] tq_wide;
    logic tq_over;
    bsc_pkg::bsc_job_t job_reg, job_next;

    assign t1 = temp_cal[15:0];
    assign t2 = temp_cal[31:16];
    assign t3 = temp_cal[39:32];

    // The whole pipe moves unless the last stage is blocked by a full queue.
    assign en        = !(vd_reg && queue_full);
    assign s_tready  = en;
    assign job_valid = vd_reg;
    assign job       = job_reg;

    always_comb begin
        d_next   = $signed({1'b0, raw_temperature}) - $signed({1'b0, t1, 8'd0});
        dt2_next = $signed({{16{d_reg[24]}}, d_reg}) * $signed({{25{t2[15]}}, t2});
        dd_next  = $signed({{25{d_reg[24]}}, d_reg}) * $signed({{25{d_reg[24]}}, d_reg});
        ddt3     = $signed({{8{dd_reg[49]}}, dd_reg}) * $signed({{50{t3[7]}}, t3});
        nt_wide  = $signed({{1{dt2_reg[40]}}, dt2_reg, 18'd0})
                 + $signed({{2{ddt3[57]}}, ddt3});
        nt_next  = nt_wide[bsc_pkg::NT_W-1:0];

        // Round to Q8.16 with ties upward, then clip to 24 bits.
        rnd      = $signed({nt_reg[bsc_pkg::NT_W-1], nt_reg}) + $signed(60'h80000000);
        tq_wide  = rnd[59:bsc_pkg::T_SHIFT];
        tq_over  = !((tq_wide[27:23] == 5'b00000) || (tq_wide[27:23] == 5'b11111));

        job_next.nt   = nt_reg;
        job_next.p    = pc_reg;
        job_next.tsat = tq_over;
        if (!tq_over) begin
            job_next.tq = tq_wide[23:0];
        end else if (tq_wide[27]) begin
            job_next.tq = bsc_pkg::TEMP_MIN;
        end else begin
            job_next.tq = bsc_pkg::TEMP_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg   <= d_next;
            pa_reg  <= raw_pressure;
            dt2_reg <= dt2_next;
            dd_reg  <= dd_next;
            pb_reg  <= pa_reg;
            nt_reg  <= nt_next;
            pc_reg  <= pb_reg;
            job_reg <= job_next;
        end
    end

endmodule

// ----- sv/bsc_back.sv -----
// ============================================================================
// bsc_back
// Pressure engine: evaluates the calibration polynomial on a 256-bit
// accumulator with one shared 32x32 multiplier, then rounds, clips and holds
// the result item in the output register.
// ============================================================================
module bsc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    press_low,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]    press_high,
    input  logic                              queue_empty,
    input  bsc_pkg::bsc_job_t                 queue_head,
    output logic                              queue_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [bsc_pkg::TEMP_W-1:0] temperature_q16,
    output logic [bsc_pkg::PRESS_W-1:0]       pressure_q8,
    output logic                              saturated
);

    localparam int unsigned W = bsc_pkg::WIDE_W;
    localparam int unsigned L = bsc_pkg::LIMB_W;

    bsc_pkg::bsc_state_t state_reg, state_next;
    logic [bsc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [bsc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    bsc_pkg::bsc_job_t job_reg, job_next;
    logic [W-1:0] r_reg, r_next, q_reg, q_next, acc_reg, acc_next;
    logic [2*L-1:0] pp_reg, pp_next;
    logic [2:0] pos_reg, pos_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic signed [bsc_pkg::TEMP_W-1:0] tq_out_reg, tq_out_next;
    logic [bsc_pkg::PRESS_W-1:0] pq_out_reg, pq_out_next;
    logic sat_out_reg, sat_out_next;

    bsc_pkg::bsc_op_t op;
    logic [W-1:0] src_word, addend, corr, pp_wide, wr_val, fin_sum;
    logic [bsc_pkg::MULT_W-1:0] m_word;
    logic hi_half;
    logic [2:0] i_idx;
    logic [L-1:0] src_limb, m_limb;
    logic fin_neg, fin_over;
    logic signed [16:0] c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9, c_p10, c_p11;
    logic signed [16:0] c_a1, c_a2;

    // Coefficients, widened to 17 signed bits.
    assign c_a1  = $signed({press_low[15], press_low[15:0]}) - 17'sd16384;
    assign c_a2  = $signed({press_low[31], press_low[31:16]}) - 17'sd16384;
    assign c_p3  = $signed({{9{press_low[39]}}, press_low[39:32]});
    assign c_p4  = $signed({{9{press_low[47]}}, press_low[47:40]});
    assign c_p5  = $signed({1'b0, press_low[63:48]});
    assign c_p6  = $signed({1'b0, press_high[15:0]});
    assign c_p7  = $signed({{9{press_high[23]}}, press_high[23:16]});
    assign c_p8  = $signed({{9{press_high[31]}}, press_high[31:24]});
    assign c_p9  = $signed({press_high[47], press_high[47:32]});
    assign c_p10 = $signed({{9{press_high[55]}}, press_high[55:48]});
    assign c_p11 = $signed({{9{press_high[63]}}, press_high[63:56]});

    assign m_tvalid        = m_tvalid_reg;
    assign temperature_q16 = tq_out_reg;
    assign pressure_q8     = pq_out_reg;
    assign saturated       = sat_out_reg;

    always_comb begin
        op       = bsc_pkg::bsc_prog(step_reg);
        src_word = (op.src == bsc_pkg::REG_Q) ? q_reg : r_reg;
        m_word   = (op.mul == bsc_pkg::MUL_T)
                 ? {{(bsc_pkg::MULT_W-bsc_pkg::NT_W){job_reg.nt[bsc_pkg::NT_W-1]}}, job_reg.nt}
                 : {{(bsc_pkg::MULT_W-bsc_pkg::RAW_W){1'b0}}, job_reg.p};

        case (op.add)
            bsc_pkg::TERM_P4:  addend = bsc_pkg::bsc_term(c_p4, 0);
            bsc_pkg::TERM_P8:  addend = bsc_pkg::bsc_term(c_p8, 22);
            bsc_pkg::TERM_P3:  addend = bsc_pkg::bsc_term(c_p3, 53);
            bsc_pkg::TERM_P7:  addend = bsc_pkg::bsc_term(c_p7, 77);
            bsc_pkg::TERM_P10: addend = bsc_pkg::bsc_term(c_p10, 85);
            bsc_pkg::TERM_A2:  addend = bsc_pkg::bsc_term(c_a2, 104);
            bsc_pkg::TERM_P6:  addend = bsc_pkg::bsc_term(c_p6, 127);
            bsc_pkg::TERM_P11: addend = bsc_pkg::bsc_term(c_p11, 116);
            bsc_pkg::TERM_P9:  addend = bsc_pkg::bsc_term(c_p9, 133);
            bsc_pkg::TERM_A1:  addend = bsc_pkg::bsc_term(c_a1, 161);
            bsc_pkg::TERM_P5:  addend = bsc_pkg::bsc_term(c_p5, 184);
            default:           addend = q_reg;
        endcase

        // Partial products: lower multiplier limb against all eight source
        // limbs, then the upper limb against the lower seven.
        hi_half  = (cnt_reg >= bsc_pkg::HI_LIMB_CNT);
        i_idx    = hi_half ? 3'(cnt_reg - bsc_pkg::HI_LIMB_CNT) : cnt_reg[2:0];
        pos_next = hi_half ? 3'(cnt_reg - 5'd7) : cnt_reg[2:0];
        src_limb = src_word[L*i_idx +: L];
        m_limb   = hi_half ? m_word[2*L-1:L] : m_word[L-1:0];
        pp_next  = {{L{1'b0}}, src_limb} * {{L{1'b0}}, m_limb};
        pp_wide  = {{(W-2*L){1'b0}}, pp_reg} << {pos_reg, 5'd0};

        // A negative multiplier word counts 2^64 too much.
        corr   = m_word[bsc_pkg::MULT_W-1] ? (src_word << bsc_pkg::MULT_W) : '0;
        wr_val = (op.kind == bsc_pkg::OP_LOAD) ? addend : (acc_reg - corr);

        // Round pressure to Pa*256 with ties upward and clip.
        fin_sum  = r_reg + (W'(1) << (bsc_pkg::P_SHIFT - 1));
        fin_neg  = fin_sum[W-1];
        fin_over = |fin_sum[W-2:bsc_pkg::P_SHIFT+bsc_pkg::PRESS_W];

        state_next    = state_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        job_next      = job_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        acc_next      = acc_reg;
        queue_pop     = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        tq_out_next   = tq_out_reg;
        pq_out_next   = pq_out_reg;
        sat_out_next  = sat_out_reg;

        unique case (state_reg)
            bsc_pkg::ST_IDLE: begin
                if (!queue_empty) begin
                    queue_pop  = 1'b1;
                    job_next   = queue_head;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = bsc_pkg::ST_RUN;
                end
            end
            bsc_pkg::ST_RUN: begin
                if (op.kind == bsc_pkg::OP_MAC && cnt_reg != bsc_pkg::MAC_LAST_CNT) begin
                    acc_next = (cnt_reg == '0) ? addend : (acc_reg + pp_wide);
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    if (op.dst == bsc_pkg::REG_Q) begin
                        q_next = wr_val;
                    end else begin
                        r_next = wr_val;
                    end
                    cnt_next = '0;
                    if (step_reg == bsc_pkg::LAST_STEP) begin
                        state_next = bsc_pkg::ST_FINISH;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            bsc_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    tq_out_next   = job_reg.tq;
                    sat_out_next  = job_reg.tsat || fin_neg || fin_over;
                    if (fin_neg) begin
                        pq_out_next = '0;
                    end else if (fin_over) begin
                        pq_out_next = bsc_pkg::PRESS_MAX;
                    end else begin
                        pq_out_next = fin_sum[bsc_pkg::P_SHIFT +: bsc_pkg::PRESS_W];
                    end
                    state_next = bsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bsc_pkg::ST_IDLE;
            step_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        pp_reg      <= pp_next;
        pos_reg     <= pos_next;
        tq_out_reg  <= tq_out_next;
        pq_out_reg  <= pq_out_next;
        sat_out_reg <= sat_out_next;
    end

endmodule
